// ===== hdl/dense_matrix_multiply_core_defines.svh =====
// ----------------------------------------------------------------------------
// Dense matrix multiply core: assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef DENSE_MATRIX_MULTIPLY_CORE_DEFINES_SVH
`define DENSE_MATRIX_MULTIPLY_CORE_DEFINES_SVH

// same-cycle implication
`define DMM_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dmm checker: same-cycle implication failed");

// next-cycle implication
`define DMM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dmm checker: next-cycle implication failed");

`endif

// ===== hdl/dmm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dense matrix multiply package
// Sizes, codes, payload types and helpers shared by the matrix multiply core.
// ----------------------------------------------------------------------------
package dmm_pkg;

   localparam int DIM         = 16;
   localparam int IDX_W       = $clog2(DIM);
   localparam int ADDR_W      = 2 * IDX_W;
   localparam int MEM_DEPTH   = DIM * DIM;
   localparam int CFG_W       = 5;
   localparam int ELEM_W      = 16;
   localparam int PROD_W      = 2 * ELEM_W;
   localparam int SUM_W       = 36;
   localparam int ACT_W       = 2;
   localparam int CSR_IDX_W   = 2;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   localparam logic [CFG_W-1:0] DIM_LIMIT = CFG_W'(DIM);
   localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

   localparam logic [ACT_W-1:0] ACT_WRITE_A = 2'd0;
   localparam logic [ACT_W-1:0] ACT_WRITE_B = 2'd1;
   localparam logic [ACT_W-1:0] ACT_COMPUTE = 2'd2;
   localparam logic [ACT_W-1:0] ACT_NONE    = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_LEFT_ROWS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INNER_SIZE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RIGHT_COLS = 2'd2;

   typedef struct packed {
      logic [ACT_W-1:0]         action;
      logic [IDX_W-1:0]         row_index;
      logic [IDX_W-1:0]         col_index;
      logic signed [ELEM_W-1:0] element_value;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]        out_row;
      logic [IDX_W-1:0]        out_col;
      logic signed [SUM_W-1:0] dot_sum;
      logic                    last_of_row;
   } rsp_type;

   typedef struct packed {
      logic [CFG_W-1:0] rows;
      logic [CFG_W-1:0] inner;
      logic [CFG_W-1:0] cols;
   } dims_type;

   // zero acts as one, anything above the store size acts as the store size
   function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] value);
      logic [CFG_W-1:0] result;
      result = value;
      if (value == '0) begin
         result = CFG_W'(1);
      end else if (value > DIM_LIMIT) begin
         result = DIM_LIMIT;
      end
      return result;
   endfunction

endpackage

// ===== hdl/dmm_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dense matrix multiply front end
// Accepts request transactions and drops those that have no effect.
// ----------------------------------------------------------------------------
module dmm_front (
   input  logic              req_valid,
   output logic              req_stall,
   input  dmm_pkg::req_type  req_data,
   input  dmm_pkg::dims_type dims,
   input  logic              queue_full,
   output logic              push_valid,
   output dmm_pkg::req_type  push_data
);

   logic keep;

   always_comb begin
      unique case (req_data.action) inside
         dmm_pkg::ACT_WRITE_A, dmm_pkg::ACT_WRITE_B: begin
            keep = 1'b1;
         end
         dmm_pkg::ACT_COMPUTE: begin
            keep = ({1'b0, req_data.row_index} < dims.rows);
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign req_stall  = queue_full;
   assign push_valid = req_valid && !queue_full && keep;
   assign push_data  = req_data;

endmodule

// ===== hdl/dmm_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dense matrix multiply command queue
// Short in-order queue between the front end and the compute engine.
// ----------------------------------------------------------------------------
module dmm_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  dmm_pkg::req_type push_data,
   output logic             full,
   input  logic             pop,
   output logic             pop_valid,
   output dmm_pkg::req_type pop_data
);

   dmm_pkg::req_type entry_ff [dmm_pkg::QUEUE_DEPTH];

   logic [dmm_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [dmm_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [dmm_pkg::QCNT_W-1:0] count_ff, count_in;
   logic                       do_pop;

   assign full      = (count_ff == dmm_pkg::QCNT_W'(dmm_pkg::QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = push_valid ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push_valid && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hdl/dmm_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dense matrix multiply engine
// Holds both matrices and walks one result row through a single MAC.
// ----------------------------------------------------------------------------
module dmm_engine (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  dmm_pkg::req_type  cmd_data,
   output logic              cmd_pop,
   input  dmm_pkg::dims_type dims,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output dmm_pkg::rsp_type  rsp_data
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_RUN    = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   logic signed [dmm_pkg::ELEM_W-1:0] left_mem_ff  [dmm_pkg::MEM_DEPTH];
   logic signed [dmm_pkg::ELEM_W-1:0] right_mem_ff [dmm_pkg::MEM_DEPTH];

   logic [1:0]                        state_ff, state_in;
   logic [dmm_pkg::IDX_W-1:0]         row_ff, row_in;
   logic [dmm_pkg::IDX_W-1:0]         col_ff, col_in;
   logic [dmm_pkg::CFG_W-1:0]         k_ff, k_in;
   logic                              rd_valid_ff, rd_valid_in;
   logic                              prod_valid_ff;
   logic signed [dmm_pkg::ELEM_W-1:0] left_rd_ff, right_rd_ff;
   logic signed [dmm_pkg::PROD_W-1:0] prod_ff;
   logic signed [dmm_pkg::SUM_W-1:0]  acc_ff, acc_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   dmm_pkg::rsp_type                  rsp_data_ff;

   logic                      acc_clear;
   logic                      rsp_load;
   logic                      out_free;
   logic                      pipe_empty;
   logic                      col_last;
   logic                      k_last;
   logic                      left_we;
   logic                      right_we;
   logic [dmm_pkg::ADDR_W-1:0] left_addr;
   logic [dmm_pkg::ADDR_W-1:0] right_addr;
   logic [dmm_pkg::ADDR_W-1:0] wr_addr;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign pipe_empty = !rd_valid_ff && !prod_valid_ff;
   assign col_last   = (({1'b0, col_ff} + dmm_pkg::CFG_W'(1)) == dims.cols);
   assign k_last     = ((k_ff + dmm_pkg::CFG_W'(1)) == dims.inner);
   assign cmd_pop    = (state_ff == ST_IDLE) && cmd_valid;
   assign left_we    = cmd_pop && (cmd_data.action == dmm_pkg::ACT_WRITE_A);
   assign right_we   = cmd_pop && (cmd_data.action == dmm_pkg::ACT_WRITE_B);
   assign wr_addr    = {cmd_data.row_index, cmd_data.col_index};
   assign left_addr  = {row_ff, k_ff[dmm_pkg::IDX_W-1:0]};
   assign right_addr = {k_ff[dmm_pkg::IDX_W-1:0], col_ff};

   always_comb begin
      state_in    = state_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      k_in        = k_ff;
      rd_valid_in = 1'b0;
      acc_clear   = 1'b0;
      rsp_load    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_pop && (cmd_data.action == dmm_pkg::ACT_COMPUTE)) begin
               row_in    = cmd_data.row_index;
               col_in    = '0;
               k_in      = '0;
               acc_clear = 1'b1;
               state_in  = ST_RUN;
            end
         end
         ST_RUN: begin
            rd_valid_in = 1'b1;
            k_in        = k_ff + dmm_pkg::CFG_W'(1);
            if (k_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (pipe_empty && out_free) begin
               rsp_load  = 1'b1;
               k_in      = '0;
               acc_clear = 1'b1;
               if (col_last) begin
                  state_in = ST_IDLE;
               end else begin
                  col_in   = col_ff + 1'b1;
                  state_in = ST_RUN;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      acc_in = acc_ff;
      if (acc_clear) begin
         acc_in = '0;
      end else if (prod_valid_ff) begin
         acc_in = acc_ff + dmm_pkg::SUM_W'(prod_ff);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rd_valid_ff   <= 1'b0;
         prod_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rd_valid_ff   <= rd_valid_in;
         prod_valid_ff <= rd_valid_ff;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff  <= row_in;
      col_ff  <= col_in;
      k_ff    <= k_in;
      acc_ff  <= acc_in;
      prod_ff <= left_rd_ff * right_rd_ff;
      if (rsp_load) begin
         rsp_data_ff.out_row     <= row_ff;
         rsp_data_ff.out_col     <= col_ff;
         rsp_data_ff.dot_sum     <= acc_ff;
         rsp_data_ff.last_of_row <= col_last;
      end
   end

   always_ff @(posedge clock) begin
      if (left_we) begin
         left_mem_ff[wr_addr] <= cmd_data.element_value;
      end
      left_rd_ff <= left_mem_ff[left_addr];
   end

   always_ff @(posedge clock) begin
      if (right_we) begin
         right_mem_ff[wr_addr] <= cmd_data.element_value;
      end
      right_rd_ff <= right_mem_ff[right_addr];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== hdl/dense_matrix_multiply_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dense matrix multiply core
// Computes rows of C = A x B on signed Q8.8 elements with exact Q.16 sums.
//
// Request channel (req_valid / req_stall / req_data): a transaction either
// writes one element of A or B, or asks for one row of C. Writes and computes
// are executed strictly in arrival order behind a two-entry command queue.
// Response channel (rsp_valid / rsp_stall / rsp_data): one transaction per
// result element, columns in ascending order, last_of_row on the final one.
// The engine takes a new command only when idle. A compute row's pace is
// set by the single multiply-accumulate unit fed by one read port on each
// matrix store. The CSR port (csr_write_enable / csr_index / csr_write_data)
// sets the matrix sizes; it must be written only while the core is idle;
// the core itself does not enforce this.
// Reset clears the control logic and sets all sizes to 16; matrix contents
// are unknown until written. A stalled response holds, the engine waits, and
// the queue fills before req_stall rises.
// ----------------------------------------------------------------------------
module dense_matrix_multiply_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  dmm_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output dmm_pkg::rsp_type                  rsp_data,
   input  logic                              csr_write_enable,
   input  logic [dmm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [dmm_pkg::CFG_W-1:0]         csr_write_data
);

   logic [dmm_pkg::CFG_W-1:0] left_rows_ff, left_rows_in;
   logic [dmm_pkg::CFG_W-1:0] inner_size_ff, inner_size_in;
   logic [dmm_pkg::CFG_W-1:0] right_cols_ff, right_cols_in;

   dmm_pkg::dims_type dims;
   dmm_pkg::req_type  push_data;
   dmm_pkg::req_type  pop_data;
   logic              push_valid;
   logic              queue_full;
   logic              pop_valid;
   logic              pop;

   always_comb begin
      left_rows_in  = left_rows_ff;
      inner_size_in = inner_size_ff;
      right_cols_in = right_cols_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            dmm_pkg::CSR_LEFT_ROWS:  left_rows_in  = csr_write_data;
            dmm_pkg::CSR_INNER_SIZE: inner_size_in = csr_write_data;
            dmm_pkg::CSR_RIGHT_COLS: right_cols_in = csr_write_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_rows_ff  <= dmm_pkg::CFG_RESET;
         inner_size_ff <= dmm_pkg::CFG_RESET;
         right_cols_ff <= dmm_pkg::CFG_RESET;
      end else begin
         left_rows_ff  <= left_rows_in;
         inner_size_ff <= inner_size_in;
         right_cols_ff <= right_cols_in;
      end
   end

   assign dims.rows  = dmm_pkg::clamp_dim(left_rows_ff);
   assign dims.inner = dmm_pkg::clamp_dim(inner_size_ff);
   assign dims.cols  = dmm_pkg::clamp_dim(right_cols_ff);

   dmm_front u_front (
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .dims       (dims),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   dmm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (queue_full),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data)
   );

   dmm_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (pop_valid),
      .cmd_data  (pop_data),
      .cmd_pop   (pop),
      .dims      (dims),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== hdl/dmm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dense matrix multiply checker
// Port-level checks on response ordering and hold behavior.
// ----------------------------------------------------------------------------
`include "dense_matrix_multiply_core_defines.svh"

module dmm_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input dmm_pkg::rsp_type rsp_data
);

   logic [dmm_pkg::IDX_W-1:0] col_exp_ff, col_exp_in;
   logic [dmm_pkg::IDX_W-1:0] row_ff, row_in;
   logic                      in_row_ff, in_row_in;
   logic                      rsp_fire;

   assign rsp_fire = rsp_valid && !rsp_stall;

   always_comb begin
      col_exp_in = col_exp_ff;
      row_in     = row_ff;
      in_row_in  = in_row_ff;
      if (rsp_fire) begin
         if (rsp_data.last_of_row) begin
            col_exp_in = '0;
            in_row_in  = 1'b0;
         end else begin
            col_exp_in = rsp_data.out_col + 1'b1;
            in_row_in  = 1'b1;
            row_in     = rsp_data.out_row;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_exp_ff <= '0;
         row_ff     <= '0;
         in_row_ff  <= 1'b0;
      end else begin
         col_exp_ff <= col_exp_in;
         row_ff     <= row_in;
         in_row_ff  <= in_row_in;
      end
   end

   `DMM_ASSERT_NEXT(rsp_hold_on_stall, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))
   `DMM_ASSERT_IMPLIES(rsp_col_in_order, clock, reset, rsp_valid, rsp_data.out_col == col_exp_ff)
   `DMM_ASSERT_IMPLIES(rsp_row_steady, clock, reset, rsp_valid && in_row_ff, rsp_data.out_row == row_ff)
   `DMM_ASSERT_IMPLIES(rsp_last_at_top_col, clock, reset, rsp_valid && (rsp_data.out_col == '1), rsp_data.last_of_row)

endmodule

bind dense_matrix_multiply_core dmm_checker u_dmm_checker (.*);
